// File: hdl/sorted_timer_queue_top_macros.svh
// Assertion macros used by the timer queue sequencer.
`ifndef SORTED_TIMER_QUEUE_TOP_MACROS_SVH
`define SORTED_TIMER_QUEUE_TOP_MACROS_SVH

// Checks that an implication holds on every rising clock edge outside reset.
`define STQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that an implication holds in the cycle after its antecedent.
`define STQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Types and codes shared by the sorted timer queue modules.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_DRAIN  = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_NO_MATCH  = 3'd3;
  localparam logic [2:0] ST_EXPIRED   = 3'd4;
  localparam logic [2:0] ST_NONE      = 3'd5;

  localparam int MAX_OUT = 32;

  // Cell operation codes.
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_POP    = 2'd3;

  // One stored timer.
  typedef struct packed {
    logic [47:0] expiry;
    logic [31:0] id;
    logic [15:0] waker;
  } entry_t;

  // Broadcast command to every cell.
  typedef struct packed {
    logic [1:0] op;
    entry_t     key;
  } cell_cmd_t;

endpackage

// File: hdl/stq_cell.sv
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted chain; compares the broadcast key and takes data
// from itself or a neighbor.
// ----------------------------------------------------------------------------
module stq_cell (
  input  logic               clk,
  input  logic               rst,
  input  stq_pkg::cell_cmd_t cmd,
  input  stq_pkg::entry_t    prev_entry,
  input  logic               prev_valid,
  input  logic               prev_after,
  input  logic               prev_hit,
  input  stq_pkg::entry_t    next_entry,
  input  logic               next_valid,
  output stq_pkg::entry_t    entry,
  output logic               valid,
  output logic               after,
  output logic               hit
);

  // after: this cell sorts strictly after the key; hit: this cell or one before it matches the key.
  assign after = valid && ((entry.expiry > cmd.key.expiry) ||
                 ((entry.expiry == cmd.key.expiry) && (entry.id > cmd.key.id)));
  assign hit = prev_hit || (valid && (entry.expiry == cmd.key.expiry) &&
                            (entry.id == cmd.key.id));

  // Payload moves by operation; the predecessor flags locate the insert spot.
  // Cells after the key shift right, and the first of them takes the key.
  always_ff @(posedge clk) begin
    case (cmd.op) inside
      stq_pkg::OP_INSERT: begin
        if (after || !valid) entry <= prev_after ? prev_entry : cmd.key;
      end
      stq_pkg::OP_REMOVE, stq_pkg::OP_POP: begin
        if (cmd.op == stq_pkg::OP_POP || hit) entry <= next_entry;
      end
      default: ;
    endcase
  end

  // Occupancy stays a contiguous run from the head.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd.op) inside
        stq_pkg::OP_INSERT: if (!valid && prev_valid) valid <= 1'b1;
        stq_pkg::OP_REMOVE, stq_pkg::OP_POP: begin
          if (cmd.op == stq_pkg::OP_POP || hit) valid <= next_valid;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/stq_ctrl.sv
// ----------------------------------------------------------------------------
// stq_ctrl
// Sequencer: decodes requests, drives the cell chain and emits results.
// ----------------------------------------------------------------------------
`include "sorted_timer_queue_top_macros.svh"
module stq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [47:0]        expiry_time,
  input  logic [31:0]        entry_id,
  input  logic [15:0]        waker_tag,
  input  logic [47:0]        current_time,
  input  logic               cancel_blocked,
  input  stq_pkg::entry_t    head,
  input  logic               head_valid,
  input  logic               tail_valid,
  input  logic               any_hit,
  output stq_pkg::cell_cmd_t cmd,
  output logic               done,
  output logic [2:0]         status,
  output logic [31:0]        result_id,
  output logic [15:0]        result_waker,
  output logic [47:0]        result_expiry,
  output logic               last
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CANCEL = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_PAD    = 2'd3;

  logic [1:0]  state;
  logic [47:0] now;
  logic [5:0]  emitted;
  logic [31:0] next_id;
  stq_pkg::entry_t key;
  logic        pop;
  logic        more;

  assign busy = (state != S_IDLE);

  // Drain pops the head when it is due and the burst limit is not reached.
  assign pop  = (state == S_DRAIN) && head_valid && (head.expiry <= now) &&
                (emitted < 6'(stq_pkg::MAX_OUT));

  // The command comes from the request in idle, or from the sequencer.
  // A cancel that is not blocked broadcasts a remove; without a match no cell moves.
  always_comb begin
    cmd.op  = stq_pkg::OP_HOLD;
    cmd.key = key;
    if (state == S_IDLE && start && action == stq_pkg::ACT_INSERT && !tail_valid) begin
      cmd.op  = stq_pkg::OP_INSERT;
      cmd.key = '{expiry: expiry_time, id: next_id, waker: waker_tag};
    end else if (state == S_CANCEL) begin
      cmd.op = stq_pkg::OP_REMOVE;
    end else if (pop) begin
      cmd.op = stq_pkg::OP_POP;
    end
  end

  // The sequencer does not look ahead; the top level resolves whether another entry follows a pop.
  assign more = 1'b0;

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      next_id <= '0;
      done    <= 1'b0;
      emitted <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            key     <= '{expiry: expiry_time, id: entry_id, waker: waker_tag};
            now     <= current_time;
            emitted <= '0;
            result_id     <= '0;
            result_waker  <= '0;
            result_expiry <= '0;
            last          <= 1'b1;
            if (action == stq_pkg::ACT_INSERT) begin
              done <= 1'b1;
              if (tail_valid) begin
                status <= stq_pkg::ST_FULL;
              end else begin
                status    <= stq_pkg::ST_INSERTED;
                result_id <= next_id;
                next_id   <= next_id + 32'd1;
              end
              state <= S_PAD;
            end else if (action == stq_pkg::ACT_CANCEL) begin
              if (cancel_blocked) begin
                done   <= 1'b1;
                status <= stq_pkg::ST_NO_MATCH;
                state  <= S_PAD;
              end else begin
                state <= S_CANCEL;
              end
            end else if (action == stq_pkg::ACT_DRAIN) begin
              state <= S_DRAIN;
            end else begin
              state <= S_PAD;
            end
          end
        end
        S_CANCEL: begin
          done   <= 1'b1;
          status <= any_hit ? stq_pkg::ST_CANCELLED : stq_pkg::ST_NO_MATCH;
          state  <= S_PAD;
        end
        S_DRAIN: begin
          if (pop) begin
            done          <= 1'b1;
            status        <= stq_pkg::ST_EXPIRED;
            result_id     <= head.id;
            result_waker  <= head.waker;
            result_expiry <= head.expiry;
            last          <= more;
            emitted       <= emitted + 6'd1;
          end else begin
            // Nothing more is due or the burst limit is reached: close the burst.
            state <= S_PAD;
            if (emitted == '0) begin
              done   <= 1'b1;
              status <= stq_pkg::ST_NONE;
              last   <= 1'b1;
            end
          end
        end
        S_PAD: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `STQ_ASSERT_IMP(a_busy_idle, clk, rst, done && state == S_IDLE, 1'b0,
    "result strobe while idle")
  `STQ_ASSERT_IMP(a_pop_due, clk, rst, pop, head.expiry <= now,
    "pop of an entry not yet due")
  `STQ_ASSERT_NEXT(a_burst_cap, clk, rst, pop, emitted <= 6'(stq_pkg::MAX_OUT),
    "drain burst over limit")

endmodule

// File: hdl/sorted_timer_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue_top
// Timer queue kept sorted by expiry and id in a chain of cells.
// ----------------------------------------------------------------------------
// Channel   Signals                                      Direction
// request   start, busy, action, expiry_time, entry_id,  in
//           waker_tag, current_time
// result    valid, status, result_id, result_waker,      out
//           result_expiry, last
// config    cfg_valid, cfg_ready, cfg_data               in
//
// Every request passes through S_PAD before the next one is accepted; a cancel
// first visits S_CANCEL unless blocked, and a drain stays in S_DRAIN while it pops.
// The chain updates every cell in the same cycle; the drain emits one entry per
// cycle from the head. Reset clears occupancy and the id counter at once.
// Results last one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_timer_queue_top #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [47:0] expiry_time,
  input  logic [31:0] entry_id,
  input  logic [15:0] waker_tag,
  input  logic [47:0] current_time,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  output logic        valid,
  output logic [2:0]  status,
  output logic [31:0] result_id,
  output logic [15:0] result_waker,
  output logic [47:0] result_expiry,
  output logic        last
);

  stq_pkg::cell_cmd_t cmd;
  stq_pkg::entry_t    ent   [CAPACITY];
  logic [CAPACITY-1:0] vld, aft, hit;
  logic cancel_blocked;
  logic raw_last;

  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) cancel_blocked <= 1'b0;
    else if (cfg_valid) cancel_blocked <= cfg_data;
  end

  // Cell chain; the head sees a valid, never-after predecessor that carries the key.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    stq_cell u_cell (
      .clk(clk), .rst(rst), .cmd(cmd),
      .prev_entry(g == 0 ? cmd.key : ent[(g == 0) ? 0 : g - 1]),
      .prev_valid(g == 0 ? 1'b1 : vld[(g == 0) ? 0 : g - 1]),
      .prev_after(g == 0 ? 1'b0 : aft[(g == 0) ? 0 : g - 1]),
      .prev_hit  (g == 0 ? 1'b0 : hit[(g == 0) ? 0 : g - 1]),
      .next_entry(g == CAPACITY - 1 ? ent[g] : ent[(g == CAPACITY - 1) ? g : g + 1]),
      .next_valid(g == CAPACITY - 1 ? 1'b0 : vld[(g == CAPACITY - 1) ? g : g + 1]),
      .entry(ent[g]), .valid(vld[g]), .after(aft[g]), .hit(hit[g])
    );
  end

  stq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .expiry_time(expiry_time), .entry_id(entry_id), .waker_tag(waker_tag),
    .current_time(current_time), .cancel_blocked(cancel_blocked),
    .head(ent[0]), .head_valid(vld[0]), .tail_valid(vld[CAPACITY-1]),
    .any_hit(hit[CAPACITY-1]), .cmd(cmd), .done(valid), .status(status),
    .result_id(result_id), .result_waker(result_waker),
    .result_expiry(result_expiry), .last(raw_last)
  );

  // An expired entry is last when the next head is not due or the burst ends;
  // the sequencer does not look ahead, so resolve it from the chain now.
  logic [47:0] now_q;
  logic [5:0]  cnt_q;
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      now_q <= current_time;
      cnt_q <= '0;
    end else if (valid) begin
      cnt_q <= cnt_q + 6'd1;
    end
  end
  assign last = (status == stq_pkg::ST_EXPIRED) ?
                (!vld[0] || ent[0].expiry > now_q ||
                 cnt_q == 6'(stq_pkg::MAX_OUT - 1)) : raw_last;

endmodule
